### hdl/afpp_pkg.sv
// ----------------------------------------------------------------------------
// afpp_pkg
// Types and constants shared by the accelerometer FIFO packet parser.
// ----------------------------------------------------------------------------
package afpp_pkg;

	localparam int BYTE_W      = 8;
	localparam int SAMPLE_W    = 16;
	localparam int AXIS_W      = 2;
	localparam int COUNT_W     = 32;
	localparam int CFG_INDEX_W = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_HEADER_MASK  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_HEADER_MATCH = CFG_INDEX_W'(1);

	localparam logic [BYTE_W-1:0] HEADER_MASK_RST  = 8'hfc;
	localparam logic [BYTE_W-1:0] HEADER_MATCH_RST = 8'h40;

	localparam int FIRST_LOW_POS   = 2;
	localparam int LAST_SAMPLE_POS = 6;

	typedef struct packed {
		logic [BYTE_W-1:0] fifo_byte;
		logic              burst_start;
	} in_word_t;

	typedef struct packed {
		logic                       sample_valid;
		logic signed [SAMPLE_W-1:0] sample_value;
		logic [AXIS_W-1:0]          axis_index;
		logic [COUNT_W-1:0]         good_packets;
		logic [COUNT_W-1:0]         bad_packets;
	} out_word_t;

	typedef struct packed {
		logic [BYTE_W-1:0] header_mask;
		logic [BYTE_W-1:0] header_match;
	} hdr_cfg_t;

endpackage

### hdl/afpp_in_if.sv
// ----------------------------------------------------------------------------
// afpp_in_if
// Byte channel into the parser: valid, ready and one input word.
// ----------------------------------------------------------------------------
interface afpp_in_if;
	import afpp_pkg::*;

	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/afpp_out_if.sv
// ----------------------------------------------------------------------------
// afpp_out_if
// Result channel out of the parser: valid, ready and one result word.
// ----------------------------------------------------------------------------
interface afpp_out_if;
	import afpp_pkg::*;

	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/afpp_cfg_if.sv
// ----------------------------------------------------------------------------
// afpp_cfg_if
// Register write channel: valid, ready, register index and write data.
// ----------------------------------------------------------------------------
interface afpp_cfg_if;
	import afpp_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [BYTE_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/afpp_cfg_regs.sv
// ----------------------------------------------------------------------------
// afpp_cfg_regs
// Header mask and match registers, written through the register channel.
// ----------------------------------------------------------------------------
module afpp_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	afpp_cfg_if.sink          cfg,
	output afpp_pkg::hdr_cfg_t hdr_cfg
);
	import afpp_pkg::*;

	hdr_cfg_t hdr_cfg_q;

	assign cfg.ready = 1'b1;
	assign hdr_cfg   = hdr_cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cfg_q.header_mask  <= HEADER_MASK_RST;
			hdr_cfg_q.header_match <= HEADER_MATCH_RST;
		end else if (cfg.valid) begin
			if (cfg.index == REG_HEADER_MASK) begin
				hdr_cfg_q.header_mask <= cfg.data;
			end
			if (cfg.index == REG_HEADER_MATCH) begin
				hdr_cfg_q.header_match <= cfg.data;
			end
		end
	end
endmodule

### hdl/afpp_in_stage.sv
// ----------------------------------------------------------------------------
// afpp_in_stage
// Input register: holds one accepted byte until the parse stage takes it.
// ----------------------------------------------------------------------------
module afpp_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	afpp_in_if.sink            bytes,
	input  logic               advance,
	output logic               valid_s1,
	output afpp_pkg::in_word_t word_s1
);
	import afpp_pkg::*;

	logic valid_q;

	assign bytes.ready = !valid_q || advance;
	assign valid_s1    = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (bytes.ready) begin
			valid_q <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			word_s1 <= bytes.data;
		end
	end
endmodule

### hdl/afpp_parse.sv
// ----------------------------------------------------------------------------
// afpp_parse
// Packet position, header check, sample assembly and packet counters.
// ----------------------------------------------------------------------------
module afpp_parse #(
	parameter int PACKET_BYTES = 8,
	parameter int COUNTER_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  afpp_pkg::in_word_t  word_s1,
	input  afpp_pkg::hdr_cfg_t  hdr_cfg,
	output afpp_pkg::out_word_t result
);
	import afpp_pkg::*;

	localparam int POS_W = $clog2(PACKET_BYTES);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);

	logic [POS_W-1:0]        pos_q;
	logic                    header_good_q;
	logic [BYTE_W-1:0]       held_high_q;
	logic [COUNTER_BITS-1:0] good_q;
	logic [COUNTER_BITS-1:0] bad_q;

	logic [POS_W-1:0]        pos;
	logic [POS_W-1:0]        pos_off;
	logic                    is_header;
	logic                    good_now;
	logic                    in_sample;
	logic                    take_high;
	logic                    emit;
	logic                    last;
	logic [COUNTER_BITS-1:0] good_next;
	logic [COUNTER_BITS-1:0] bad_next;

	always_comb begin
		pos       = word_s1.burst_start ? '0 : pos_q;
		pos_off   = pos - POS_W'(FIRST_LOW_POS);
		is_header = (pos == '0);
		good_now  = is_header
			? ((word_s1.fifo_byte & hdr_cfg.header_mask) == hdr_cfg.header_match)
			: header_good_q;
		in_sample = !is_header && header_good_q && (pos <= POS_W'(LAST_SAMPLE_POS));
		take_high = in_sample && pos[0];
		emit      = in_sample && !pos[0];
		last      = (pos == LAST_POS);
		good_next = (last && good_now) ? good_q + 1'b1 : good_q;
		bad_next  = (last && !good_now) ? bad_q + 1'b1 : bad_q;

		result.sample_valid = emit;
		result.sample_value = emit ? {held_high_q, word_s1.fifo_byte} : '0;
		result.axis_index   = emit ? pos_off[AXIS_W:1] : '0;
		result.good_packets = COUNT_W'(good_next);
		result.bad_packets  = COUNT_W'(bad_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			header_good_q <= 1'b0;
			good_q        <= '0;
			bad_q         <= '0;
		end else if (advance) begin
			pos_q         <= last ? '0 : pos + 1'b1;
			header_good_q <= good_now;
			good_q        <= good_next;
			bad_q         <= bad_next;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && take_high) begin
			held_high_q <= word_s1.fifo_byte;
		end
	end
endmodule

### hdl/afpp_out_reg.sv
// ----------------------------------------------------------------------------
// afpp_out_reg
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module afpp_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  afpp_pkg::out_word_t result,
	output logic                free,
	afpp_out_if.source          samples
);
	import afpp_pkg::*;

	logic      valid_q;
	out_word_t word_q;

	assign free          = !valid_q || samples.ready;
	assign samples.valid = valid_q;
	assign samples.data  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= result;
		end
	end
endmodule

### hdl/accel_fifo_packet_parser.sv
// ----------------------------------------------------------------------------
// accel_fifo_packet_parser
// Byte-serial parser for accelerometer FIFO bursts: header check, samples
// and packet counters, one result word per byte.
// An accepted byte is held in the input register, and its result word then in the result register.
// Throughput: one byte per cycle, set by the input and result registers, while the sink takes each result word.
// Reset clears packet position, header flag and counters; the header mask and
// match registers return to 0xfc and 0x40.
// ----------------------------------------------------------------------------
module accel_fifo_packet_parser #(
	parameter int PACKET_BYTES = 8,
	parameter int COUNTER_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	afpp_in_if.sink    bytes,
	afpp_out_if.source samples,
	afpp_cfg_if.sink   cfg
);
	import afpp_pkg::*;

	hdr_cfg_t  hdr_cfg;
	in_word_t  word_s1;
	out_word_t result;
	logic      valid_s1;
	logic      free;
	logic      advance;

	assign advance = valid_s1 && free;

	afpp_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.hdr_cfg (hdr_cfg)
	);

	afpp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.bytes    (bytes),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	afpp_parse #(
		.PACKET_BYTES (PACKET_BYTES),
		.COUNTER_BITS (COUNTER_BITS)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.word_s1 (word_s1),
		.hdr_cfg (hdr_cfg),
		.result  (result)
	);

	afpp_out_reg u_out_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance),
		.result  (result),
		.free    (free),
		.samples (samples)
	);
endmodule
